[rtl/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge
`define MTF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define MTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mtf_pkg.sv]
package mtf_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int DATA_W     = 8;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W      = DATA_W + 1;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_XFORM  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic              app_en;
        logic [IDX_W-1:0]  app_pos;
        logic [DATA_W-1:0] app_sym;
        logic              move_en;
        logic [IDX_W-1:0]  move_pos;
        logic [DATA_W-1:0] front;
    } ctl_t;

    typedef struct packed {
        logic             busy;
        logic [LEN_W-1:0] len;
    } stat_t;

endpackage

[rtl/mtf_if.sv]
interface mtf_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [mtf_pkg::DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mtf_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [mtf_pkg::DATA_W-1:0] result_value;
    logic [1:0]                 status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

[rtl/mtf_cell.sv]
module mtf_cell (
    input  logic                       clk,
    input  mtf_pkg::ctl_t              ctl,
    input  logic [mtf_pkg::IDX_W-1:0]  cell_idx,
    input  logic [mtf_pkg::DATA_W-1:0] prev_sym,
    input  logic [mtf_pkg::DATA_W-1:0] next_probe,
    output logic [mtf_pkg::DATA_W-1:0] sym,
    output logic [mtf_pkg::DATA_W-1:0] probe
);

    logic [mtf_pkg::DATA_W-1:0] sym_reg;
    logic [mtf_pkg::DATA_W-1:0] sym_next;
    logic [mtf_pkg::DATA_W-1:0] probe_reg;
    logic [mtf_pkg::DATA_W-1:0] probe_next;

    always_comb
    begin
        sym_next = sym_reg;
        if (ctl.app_en && (ctl.app_pos == cell_idx))
        begin
            sym_next = ctl.app_sym;
        end
        else if (ctl.move_en && (cell_idx <= ctl.move_pos))
        begin
            sym_next = (cell_idx == '0) ? ctl.front : prev_sym;
        end

        probe_next = probe_reg;
        if (ctl.load)
        begin
            probe_next = sym_reg;
        end
        else if (ctl.shift)
        begin
            probe_next = next_probe;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        probe_reg <= probe_next;
    end

    assign sym   = sym_reg;
    assign probe = probe_reg;

endmodule

[rtl/mtf_ctrl.sv]
module mtf_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    mtf_req_if.sink                    req,
    mtf_rsp_if.source                  rsp,
    input  logic [mtf_pkg::DATA_W-1:0] probe0,
    output mtf_pkg::ctl_t              ctl,
    output mtf_pkg::stat_t             stat
);

    mtf_pkg::state_t             state_reg, state_next;
    logic [mtf_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [mtf_pkg::IDX_W-1:0]   cnt_reg, cnt_next;
    logic [mtf_pkg::DATA_W-1:0]  key_reg, key_next;
    logic                        mode_reg;
    logic                        ovalid_reg, ovalid_next;
    logic [mtf_pkg::DATA_W-1:0]  ores_reg, ores_next;
    mtf_pkg::status_t            ost_reg, ost_next;
    logic                        out_free;
    logic                        hit;
    logic [mtf_pkg::CMP_W-1:0]   len_ext;
    logic [mtf_pkg::CMP_W-1:0]   cnt_ext;

    assign out_free = !ovalid_reg || rsp.ready;
    assign len_ext  = mtf_pkg::CMP_W'(len_reg);
    assign cnt_ext  = mtf_pkg::CMP_W'(cnt_reg);
    assign hit      = mode_reg ? (cnt_ext == mtf_pkg::CMP_W'(key_reg)) : (probe0 == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        ovalid_next = rsp.ready ? 1'b0 : ovalid_reg;
        ores_next   = ores_reg;
        ost_next    = ost_reg;
        req.ready   = (state_reg == mtf_pkg::S_IDLE) && out_free;

        ctl          = '0;
        ctl.app_pos  = len_reg[mtf_pkg::IDX_W-1:0];
        ctl.app_sym  = req.value;
        ctl.move_pos = cnt_reg;
        ctl.front    = probe0;

        case (state_reg)
            mtf_pkg::S_IDLE:
            begin
                if (req.valid && out_free)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = '0;
                    ost_next    = mtf_pkg::ST_OK;
                    case (mtf_pkg::req_t'(req.req_type))
                        mtf_pkg::REQ_CLEAR:
                        begin
                            len_next = '0;
                        end
                        mtf_pkg::REQ_APPEND:
                        begin
                            if (len_reg == mtf_pkg::LEN_W'(mtf_pkg::LIST_DEPTH))
                            begin
                                ost_next = mtf_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.app_en = 1'b1;
                                len_next   = len_reg + mtf_pkg::LEN_W'(1);
                            end
                        end
                        mtf_pkg::REQ_XFORM:
                        begin
                            if (mode_reg && ({1'b0, req.value} >= len_ext))
                            begin
                                ost_next = mtf_pkg::ST_BAD_INDEX;
                            end
                            else if (!mode_reg && (len_reg == '0))
                            begin
                                ost_next = mtf_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                ovalid_next = 1'b0;
                                ctl.load    = 1'b1;
                                key_next    = req.value;
                                cnt_next    = '0;
                                state_next  = mtf_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            ost_next = mtf_pkg::ST_OK;
                        end
                    endcase
                end
            end
            mtf_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    ctl.move_en = 1'b1;
                    ovalid_next = 1'b1;
                    ores_next   = mode_reg ? probe0 : mtf_pkg::DATA_W'(cnt_reg);
                    ost_next    = mtf_pkg::ST_OK;
                    state_next  = mtf_pkg::S_IDLE;
                end
                else if (!mode_reg && ((cnt_ext + mtf_pkg::CMP_W'(1)) == len_ext))
                begin
                    ovalid_next = 1'b1;
                    ores_next   = '0;
                    ost_next    = mtf_pkg::ST_NOT_FOUND;
                    state_next  = mtf_pkg::S_IDLE;
                end
                else
                begin
                    ctl.shift = 1'b1;
                    cnt_next  = cnt_reg + mtf_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                state_next = mtf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mtf_pkg::S_IDLE;
            len_reg    <= '0;
            mode_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        key_reg  <= key_next;
        ores_reg <= ores_next;
        ost_reg  <= ost_next;
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.result_value = ores_reg;
    assign rsp.status       = ost_reg;

    assign stat.busy = (state_reg == mtf_pkg::S_SCAN);
    assign stat.len  = len_reg;

endmodule

[rtl/move_to_front_coder_top.sv]
// Move-to-front coder. Load the list with a clear item and append items, set
// decode_mode through cfg_we/cfg_wdata while idle, then send transform items.
// Clear, append, ignored items and early errors (list full, index beyond the
// list, encode on an empty list) answer in the cycle after acceptance. A
// transform walks a probe chain past the cells one position per cycle: a hit
// at list position k answers and moves the symbol to the front in the same
// edge; an encode miss answers not found at the last list entry. One
// item is worked on at a time; the next is accepted once the result register
// is free. List contents are undefined after reset and need no clearing pass.
`include "assert_macros.svh"

module move_to_front_coder_top (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    mtf_req_if.sink   req,
    mtf_rsp_if.source rsp
);

    mtf_pkg::ctl_t              ctl;
    mtf_pkg::stat_t             stat;
    logic [mtf_pkg::DATA_W-1:0] sym   [mtf_pkg::LIST_DEPTH];
    logic [mtf_pkg::DATA_W-1:0] probe [mtf_pkg::LIST_DEPTH];
    logic                       clear_acc;

    mtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .probe0    (probe[0]),
        .ctl       (ctl),
        .stat      (stat)
    );

    for (genvar i = 0; i < mtf_pkg::LIST_DEPTH; i++)
    begin : g_cell
        logic [mtf_pkg::DATA_W-1:0] prev_sym;
        logic [mtf_pkg::DATA_W-1:0] next_probe;

        if (i == 0)
        begin : g_head
            assign prev_sym = ctl.front;
        end
        else
        begin : g_body
            assign prev_sym = sym[i-1];
        end

        if (i == mtf_pkg::LIST_DEPTH - 1)
        begin : g_tail
            assign next_probe = probe[i];
        end
        else
        begin : g_mid
            assign next_probe = probe[i+1];
        end

        mtf_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .cell_idx   (mtf_pkg::IDX_W'(i)),
            .prev_sym   (prev_sym),
            .next_probe (next_probe),
            .sym        (sym[i]),
            .probe      (probe[i])
        );
    end

    assign clear_acc = req.valid && req.ready && (req.req_type == mtf_pkg::REQ_CLEAR);

    `MTF_ASSERT(a_len_bound, stat.len <= mtf_pkg::LEN_W'(mtf_pkg::LIST_DEPTH), "length exceeds depth")
    `MTF_ASSERT(a_no_accept_busy, !(stat.busy && req.ready), "item accepted during scan")
    `MTF_ASSERT(a_move_in_scan, !ctl.move_en || stat.busy, "move outside scan")
    `MTF_ASSERT_NEXT(a_clear_len, clear_acc, stat.len == '0, "clear left entries")

endmodule

[tb/sv/move_to_front_coder_top_test.sv]
module move_to_front_coder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mtf_pkg::*;

    localparam int ITEM_TARGET   = 1550;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = LIST_DEPTH + 44;
    localparam int N_DIRECTED    = 22;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } coded_t;

    typedef struct packed {
        logic              mode;
        req_t              rt;
        logic [DATA_W-1:0] v;
        logic              typed;
        coded_t            want;
    } step_row_t;

    localparam step_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, REQ_XFORM,  8'h41, 1'b1, '{8'h00, ST_NOT_FOUND}},
        '{1'b0, REQ_NONE,   8'hff, 1'b1, '{8'h00, ST_OK}},
        '{1'b1, REQ_XFORM,  8'h00, 1'b1, '{8'h00, ST_BAD_INDEX}},
        '{1'b1, REQ_XFORM,  8'hff, 1'b1, '{8'h00, ST_BAD_INDEX}},
        '{1'b1, REQ_CLEAR,  8'h00, 1'b1, '{8'h00, ST_OK}},
        '{1'b1, REQ_APPEND, 8'h00, 1'b1, '{8'h00, ST_OK}},
        '{1'b1, REQ_APPEND, 8'hff, 1'b1, '{8'h00, ST_OK}},
        '{1'b1, REQ_APPEND, 8'h41, 1'b1, '{8'h00, ST_OK}},
        '{1'b1, REQ_APPEND, 8'h41, 1'b1, '{8'h00, ST_OK}},
        '{1'b1, REQ_XFORM,  8'h03, 1'b0, '{8'h00, ST_OK}},
        '{1'b1, REQ_XFORM,  8'h04, 1'b1, '{8'h00, ST_BAD_INDEX}},
        '{1'b1, REQ_XFORM,  8'h00, 1'b0, '{8'h00, ST_OK}},
        '{1'b0, REQ_XFORM,  8'hff, 1'b0, '{8'h00, ST_OK}},
        '{1'b0, REQ_XFORM,  8'h41, 1'b0, '{8'h00, ST_OK}},
        '{1'b0, REQ_XFORM,  8'h55, 1'b1, '{8'h00, ST_NOT_FOUND}},
        '{1'b0, REQ_XFORM,  8'h00, 1'b0, '{8'h00, ST_OK}},
        '{1'b0, REQ_NONE,   8'h00, 1'b1, '{8'h00, ST_OK}},
        '{1'b0, REQ_APPEND, 8'h80, 1'b1, '{8'h00, ST_OK}},
        '{1'b0, REQ_XFORM,  8'h80, 1'b0, '{8'h00, ST_OK}},
        '{1'b0, REQ_CLEAR,  8'hff, 1'b1, '{8'h00, ST_OK}},
        '{1'b0, REQ_XFORM,  8'h00, 1'b1, '{8'h00, ST_NOT_FOUND}},
        '{1'b1, REQ_XFORM,  8'h00, 1'b1, '{8'h00, ST_BAD_INDEX}}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    mtf_req_if req_ch();
    mtf_rsp_if rsp_ch();

    move_to_front_coder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [DATA_W-1:0] mtf_list [LIST_DEPTH];
    int                mtf_len;
    logic              decode_shadow;
    coded_t            coded_q [$];
    int                items_sent;
    int                loads_done;
    int                fail_count;
    int                cycle_count;
    int                status_seen [4];
    bit                steady;

    always #5 clk = ~clk;

    function automatic coded_t mtf_code(req_t rt, logic [DATA_W-1:0] v);
        coded_t            r;
        int                pos;
        int                i;
        logic [DATA_W-1:0] sym;
        r        = '0;
        r.status = ST_OK;
        pos      = -1;
        case (rt)
            REQ_CLEAR:
            begin
                mtf_len = 0;
            end
            REQ_APPEND:
            begin
                if (mtf_len >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    mtf_list[mtf_len] = v;
                    mtf_len++;
                end
            end
            REQ_XFORM:
            begin
                if (decode_shadow)
                begin
                    if (int'(v) >= mtf_len)
                    begin
                        r.status = ST_BAD_INDEX;
                    end
                    else
                    begin
                        pos     = int'(v);
                        r.value = mtf_list[pos];
                    end
                end
                else
                begin
                    for (i = mtf_len - 1; i >= 0; i--)
                    begin
                        if (mtf_list[i] == v)
                        begin
                            pos = i;
                        end
                    end
                    if (pos >= 0)
                    begin
                        r.value = pos[DATA_W-1:0];
                    end
                    else
                    begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (pos >= 0)
        begin
            sym = mtf_list[pos];
            for (i = pos; i > 0; i--)
            begin
                mtf_list[i] = mtf_list[i-1];
            end
            mtf_list[0] = sym;
        end
        return r;
    endfunction

    task automatic send_item(input req_t rt, input logic [DATA_W-1:0] v, input logic typed,
                             input coded_t want);
        coded_t pred;
        steady = (items_sent >= 700 && items_sent < 950);
        while (!steady && $urandom_range(99) < 29)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.value    <= v;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        pred = mtf_code(rt, v);
        coded_q.insert(coded_q.size(), typed ? want : pred);
        if (rt != REQ_NONE)
        begin
            items_sent++;
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (coded_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_mode(input logic m);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we        <= 1'b0;
        decode_shadow = m;
    endtask

    always @(posedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 29);
    end

    always @(posedge clk)
    begin
        coded_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (coded_q.size() == 0)
            begin
                $error("result with no item outstanding: result_value %0d status %0d",
                       rsp_ch.result_value, rsp_ch.status);
                fail_count++;
            end
            else
            begin
                want = coded_q.pop_front();
                status_seen[int'(want.status)]++;
                if (rsp_ch.result_value !== want.value)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           want.value, rsp_ch.result_value);
                    fail_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("move_to_front_coder_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int   row;
        int   episode;
        int   n_syms;
        int   n_dup;
        int   n_xf;
        int   k;
        int   idx;
        int   lim;
        int   pick;
        bit   chosen [LIST_DEPTH];
        logic m;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_CLEAR;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        mtf_len         = 0;
        decode_shadow   = 1'b0;
        steady          = 1'b0;
        items_sent      = 0;
        loads_done      = 0;
        fail_count      = 0;
        cycle_count     = 0;
        for (k = 0; k < 4; k++)
        begin
            status_seen[k] = 0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < N_DIRECTED; row++)
        begin
            if (DIRECTED[row].mode != decode_shadow)
            begin
                set_mode(DIRECTED[row].mode);
            end
            send_item(DIRECTED[row].rt, DIRECTED[row].v, DIRECTED[row].typed,
                      DIRECTED[row].want);
        end

        episode = 0;
        while (items_sent < ITEM_TARGET)
        begin
            m = 1'($urandom_range(1));
            set_mode(m);

            if (episode == 0 || episode == 9 || episode == 23)
            begin
                n_syms = (episode == 9) ? 250 : LIST_DEPTH;
                n_dup  = LIST_DEPTH - n_syms;
            end
            else if (mtf_len > 0 && $urandom_range(3) == 0)
            begin
                n_syms = 0;
                n_dup  = 0;
            end
            else
            begin
                n_syms = ($urandom_range(7) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
                n_dup  = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
            end

            if (n_syms > 0)
            begin
                loads_done++;
                send_item(REQ_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
                for (k = 0; k < LIST_DEPTH; k++)
                begin
                    chosen[k] = (n_syms == LIST_DEPTH);
                end
                k = (n_syms == LIST_DEPTH) ? n_syms : 0;
                while (k < n_syms)
                begin
                    idx = $urandom_range(LIST_DEPTH - 1);
                    if (!chosen[idx])
                    begin
                        chosen[idx] = 1'b1;
                        k++;
                    end
                end
                for (k = 0; k < LIST_DEPTH; k++)
                begin
                    if (chosen[k])
                    begin
                        send_item(REQ_APPEND, k[DATA_W-1:0], 1'b0, '0);
                    end
                end
                for (k = 0; k < n_dup; k++)
                begin
                    send_item(REQ_APPEND, mtf_list[$urandom_range(mtf_len - 1)], 1'b0, '0);
                end
                if (mtf_len == LIST_DEPTH)
                begin
                    send_item(REQ_APPEND, 8'($urandom_range(255)), 1'b0, '0);
                    send_item(REQ_XFORM, decode_shadow ? 8'hff : mtf_list[LIST_DEPTH-1],
                              1'b0, '0);
                end
            end

            n_xf = $urandom_range(10, 50);
            for (k = 0; k < n_xf; k++)
            begin
                pick = $urandom_range(99);
                if (mtf_len != 0 && pick < 80)
                begin
                    lim = (mtf_len > 4) ? 3 : mtf_len - 1;
                    idx = $urandom_range(1) ? $urandom_range(mtf_len - 1) : $urandom_range(lim);
                    send_item(REQ_XFORM, decode_shadow ? idx[DATA_W-1:0] : mtf_list[idx],
                              1'b0, '0);
                end
                else if (pick < 90)
                begin
                    send_item(REQ_XFORM, 8'($urandom_range(255)), 1'b0, '0);
                end
                else if (pick < 95)
                begin
                    send_item(REQ_NONE, 8'($urandom_range(255)), 1'b0, '0);
                end
                else if (pick < 98)
                begin
                    send_item(REQ_APPEND, 8'($urandom_range(255)), 1'b0, '0);
                end
                else
                begin
                    send_item(REQ_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
                end
            end
            episode++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d items over %0d list loads and %0d mode settings; results ok %0d,",
                 items_sent, loads_done, episode, status_seen[ST_OK]);
        $display("unknown symbol %0d, index beyond list %0d, list full %0d",
                 status_seen[ST_NOT_FOUND], status_seen[ST_BAD_INDEX], status_seen[ST_FULL]);
        if (fail_count == 0)
        begin
            $display("move_to_front_coder_top regression: pass");
        end
        else
        begin
            $display("move_to_front_coder_top regression: fail");
        end
        $finish;
    end

endmodule
